// ===== rtl/core/imm_pkg.sv =====
// Shared constants, types and helpers for the integer matrix multiplier.
package imm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int CELLS     = MAX_DIM * MAX_DIM;
   localparam int CNT_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int IDX_W     = 3;
   localparam int DATA_W    = 32;
   localparam int DIM_W     = 4;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      REQ_WRITE_A = 2'd0,
      REQ_WRITE_B = 2'd1,
      REQ_COMPUTE = 2'd2
   } req_code_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WAIT  = 3'b010,
      ST_ISSUE = 3'b100
   } state_type;

   // tag that travels with each read down the MAC pipeline
   typedef struct packed {
      logic             first;
      logic             last;
      logic             fin;
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
   } tag_type;

   // effective dimension minus one: zero acts as one, large values clamp
   function automatic logic [CNT_W-1:0] dim_last(input logic [DIM_W-1:0] r);
      logic [CNT_W-1:0] res;
      if (r == '0) begin
         res = '0;
      end else if (int'(r) > MAX_DIM) begin
         res = CNT_W'(MAX_DIM - 1);
      end else begin
         res = CNT_W'(r - DIM_W'(1));
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/imm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module imm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/integer_matrix_multiply.sv =====
// Integer matrix multiplier: top level with element stores, sequencer and MAC pipeline.
//
// Matrices A and B live in two MAX_DIM x MAX_DIM RAMs of signed 32-bit words,
// addressed row*MAX_DIM+col. A write transfer (req_type 0 for A, 1 for B)
// writes its RAM; writes may come back to back while idle, and any with row or column
// outside the store and request code 3 are dropped silently. A compute
// transfer produces rows_a x cols_b results in row-major order, the last one
// flagged by rsp_last_product; each result is the 32-bit wrapped sum over
// inner_dim products. Register values of 0 act as 1, values above MAX_DIM act
// as MAX_DIM, and are sampled when the compute is accepted. One
// multiply-accumulate unit handles all products: per result the sequencer
// issues inner_dim RAM reads on consecutive cycles, then waits for the
// pipeline (RAM read, multiply, accumulate) to drain and for the output
// register to free up before starting the next result. req_ready is low
// while a compute issues its reads; it returns high after the last read,
// before the last result is taken. Every element read by a compute must
// have been written beforehand. csr_ready is always high; registers should
// only be written while idle.
module integer_matrix_multiply (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [imm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [imm_pkg::DIM_W-1:0]            csr_data,
   // requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_type,
   input  logic [imm_pkg::IDX_W-1:0]            req_elem_row,
   input  logic [imm_pkg::IDX_W-1:0]            req_elem_col,
   input  logic signed [imm_pkg::DATA_W-1:0]    req_elem_value,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [imm_pkg::DATA_W-1:0]    rsp_prod_value,
   output logic [imm_pkg::IDX_W-1:0]            rsp_prod_row,
   output logic [imm_pkg::IDX_W-1:0]            rsp_prod_col,
   output logic                                 rsp_last_product
);

   // configuration registers
   logic [imm_pkg::DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;

   // sequencer
   imm_pkg::state_type         state_ff, state_in;
   logic [imm_pkg::CNT_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [imm_pkg::CNT_W-1:0]  nr_last_ff, nr_last_in;
   logic [imm_pkg::CNT_W-1:0]  nk_last_ff, nk_last_in;
   logic [imm_pkg::CNT_W-1:0]  nc_last_ff, nc_last_in;

   // MAC pipeline
   logic                       s1_vld_ff, s2_vld_ff;
   imm_pkg::tag_type           issue_tag, s1_tag_ff, s2_tag_ff;
   logic [imm_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic [imm_pkg::DATA_W-1:0] acc_ff, acc_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [imm_pkg::DATA_W-1:0] rsp_value_ff;
   logic [imm_pkg::IDX_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic                       rsp_last_ff;

   // RAM hookup
   logic                       issue;
   logic                       wr_in_range;
   logic                       wr_a, wr_b;
   logic [imm_pkg::ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [imm_pkg::DATA_W-1:0] rd_a, rd_b;
   logic                       req_xfer, out_free, fin_elem;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == imm_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign issue     = (state_ff == imm_pkg::ST_ISSUE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin_elem  = (i_ff == nr_last_ff) && (j_ff == nc_last_ff);

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= imm_pkg::DIM_W'(8);
         inner_dim_ff <= imm_pkg::DIM_W'(8);
         cols_b_ff    <= imm_pkg::DIM_W'(8);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            imm_pkg::CSR_ROWS_A:    rows_a_ff    <= csr_data;
            imm_pkg::CSR_INNER_DIM: inner_dim_ff <= csr_data;
            imm_pkg::CSR_COLS_B:    cols_b_ff    <= csr_data;
            default: ;  // index beyond the list: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // element writes: straight into the RAMs
   // ---------------------------------------------------------------------
   assign wr_in_range = (int'(req_elem_row) < imm_pkg::MAX_DIM) &&
                        (int'(req_elem_col) < imm_pkg::MAX_DIM);
   assign wr_a = req_xfer && wr_in_range && (req_type == imm_pkg::REQ_WRITE_A);
   assign wr_b = req_xfer && wr_in_range && (req_type == imm_pkg::REQ_WRITE_B);
   assign wr_addr = imm_pkg::ADDR_W'(req_elem_row) * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM)
                  + imm_pkg::ADDR_W'(req_elem_col);

   // read addresses: A[i][k], B[k][j]
   assign rd_addr_a = imm_pkg::ADDR_W'(i_ff) * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM)
                    + imm_pkg::ADDR_W'(k_ff);
   assign rd_addr_b = imm_pkg::ADDR_W'(k_ff) * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM)
                    + imm_pkg::ADDR_W'(j_ff);

   imm_ram #(
      .WIDTH (imm_pkg::DATA_W),
      .DEPTH (imm_pkg::CELLS)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_elem_value)),
      .rd_en   (issue),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   imm_ram #(
      .WIDTH (imm_pkg::DATA_W),
      .DEPTH (imm_pkg::CELLS)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_elem_value)),
      .rd_en   (issue),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   // ---------------------------------------------------------------------
   // sequencer: walks i, j, k; one RAM read pair per ISSUE cycle
   // ---------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      nr_last_in = nr_last_ff;
      nk_last_in = nk_last_ff;
      nc_last_in = nc_last_ff;
      unique case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (req_xfer && (req_type == imm_pkg::REQ_COMPUTE)) begin
               i_in       = '0;
               j_in       = '0;
               k_in       = '0;
               nr_last_in = imm_pkg::dim_last(rows_a_ff);
               nk_last_in = imm_pkg::dim_last(inner_dim_ff);
               nc_last_in = imm_pkg::dim_last(cols_b_ff);
               state_in   = imm_pkg::ST_WAIT;
            end
         end
         imm_pkg::ST_WAIT: begin
            // previous element fully drained and the output slot is free
            if (!s1_vld_ff && !s2_vld_ff && out_free) begin
               state_in = imm_pkg::ST_ISSUE;
            end
         end
         imm_pkg::ST_ISSUE: begin
            if (k_ff == nk_last_ff) begin
               k_in = '0;
               if (fin_elem) begin
                  state_in = imm_pkg::ST_IDLE;
               end else begin
                  state_in = imm_pkg::ST_WAIT;
                  if (j_ff == nc_last_ff) begin
                     j_in = '0;
                     i_in = i_ff + imm_pkg::CNT_W'(1);
                  end else begin
                     j_in = j_ff + imm_pkg::CNT_W'(1);
                  end
               end
            end else begin
               k_in = k_ff + imm_pkg::CNT_W'(1);
            end
         end
         default: state_in = imm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      nr_last_ff <= nr_last_in;
      nk_last_ff <= nk_last_in;
      nc_last_ff <= nc_last_in;
   end

   // ---------------------------------------------------------------------
   // MAC pipeline: RAM read -> multiply -> accumulate
   // ---------------------------------------------------------------------
   always_comb begin
      issue_tag.first = (k_ff == '0);
      issue_tag.last  = (k_ff == nk_last_ff);
      issue_tag.fin   = fin_elem;
      issue_tag.row   = i_ff;
      issue_tag.col   = j_ff;
   end

   // low 32 bits are the same for signed and unsigned operands
   assign prod_in = rd_a * rd_b;
   assign acc_in  = (s2_tag_ff.first ? '0 : acc_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_tag_ff <= issue_tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= prod_in;
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------------------------------------------------------------
   // output register; the sequencer only starts an element when it is free
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_vld_ff && s2_tag_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s2_vld_ff && s2_tag_ff.last) begin
         rsp_value_ff <= acc_in;
         rsp_row_ff   <= imm_pkg::IDX_W'(s2_tag_ff.row);
         rsp_col_ff   <= imm_pkg::IDX_W'(s2_tag_ff.col);
         rsp_last_ff  <= s2_tag_ff.fin;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prod_value   = $signed(rsp_value_ff);
   assign rsp_prod_row     = rsp_row_ff;
   assign rsp_prod_col     = rsp_col_ff;
   assign rsp_last_product = rsp_last_ff;

endmodule

// ===== rtl/core/imm_checker.sv =====
// Port-level assertions for the integer matrix multiplier, bound to the top level.
module imm_port_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [imm_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [imm_pkg::DIM_W-1:0]          csr_data,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [1:0]                         req_type,
   input logic [imm_pkg::IDX_W-1:0]          req_elem_row,
   input logic [imm_pkg::IDX_W-1:0]          req_elem_col,
   input logic signed [imm_pkg::DATA_W-1:0]  req_elem_value,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [imm_pkg::DATA_W-1:0]  rsp_prod_value,
   input logic [imm_pkg::IDX_W-1:0]          rsp_prod_row,
   input logic [imm_pkg::IDX_W-1:0]          rsp_prod_col,
   input logic                               rsp_last_product
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prod_value) &&
      $stable(rsp_prod_row) && $stable(rsp_prod_col) && $stable(rsp_last_product))
      else $error("result changed while stalled");

   // a compute transfer blocks further requests while its reads run
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == imm_pkg::REQ_COMPUTE) |=> !req_ready)
      else $error("request taken right after a compute");

   // result coordinates stay inside the store
   a_rsp_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_prod_row) < imm_pkg::MAX_DIM) &&
                    (int'(rsp_prod_col) < imm_pkg::MAX_DIM))
      else $error("result index out of range");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind integer_matrix_multiply imm_port_checker u_imm_checker (.*);

// ===== tb/imm_checker.sv =====
// Result checker for the integer matrix multiplier: tracks stores and registers, predicts products.
module imm_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [imm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [imm_pkg::DIM_W-1:0]            csr_data,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [1:0]                           req_type,
   input  logic [imm_pkg::IDX_W-1:0]            req_elem_row,
   input  logic [imm_pkg::IDX_W-1:0]            req_elem_col,
   input  logic signed [imm_pkg::DATA_W-1:0]    req_elem_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [imm_pkg::DATA_W-1:0]    rsp_prod_value,
   input  logic [imm_pkg::IDX_W-1:0]            rsp_prod_row,
   input  logic [imm_pkg::IDX_W-1:0]            rsp_prod_col,
   input  logic                                 rsp_last_product,
   output int                                   mismatch_count,
   output int                                   pending_count
);
   import imm_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic              last;
   } product_type;

   product_type       expected_products[$];
   logic [DATA_W-1:0] store_a [MAX_DIM][MAX_DIM];
   logic [DATA_W-1:0] store_b [MAX_DIM][MAX_DIM];
   logic [DIM_W-1:0]  rows_reg;
   logic [DIM_W-1:0]  inner_reg;
   logic [DIM_W-1:0]  cols_reg;
   int                errors;

   // 0 acts as 1, anything above MAX_DIM clamps
   function automatic int dim_used(input logic [DIM_W-1:0] r);
      if (r == '0) return 1;
      if (int'(r) > MAX_DIM) return MAX_DIM;
      return int'(r);
   endfunction

   task automatic predict_products();
      int                nr;
      int                nk;
      int                nc;
      logic [DATA_W-1:0] acc;
      product_type       p;
      nr = dim_used(rows_reg);
      nk = dim_used(inner_reg);
      nc = dim_used(cols_reg);
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
               acc = acc + store_a[i][k] * store_b[k][j];
            end
            p.value = acc;
            p.row   = IDX_W'(i);
            p.col   = IDX_W'(j);
            p.last  = (i == nr - 1) && (j == nc - 1);
            expected_products.push_back(p);
         end
      end
   endtask

   always @(posedge clock) begin
      product_type exp_p;
      if (reset) begin
         expected_products.delete();
         rows_reg  = DIM_W'(8);
         inner_reg = DIM_W'(8);
         cols_reg  = DIM_W'(8);
         errors    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS_A:    rows_reg  = csr_data;
               CSR_INNER_DIM: inner_reg = csr_data;
               CSR_COLS_B:    cols_reg  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_WRITE_A: begin
                  if (int'(req_elem_row) < MAX_DIM && int'(req_elem_col) < MAX_DIM)
                     store_a[req_elem_row][req_elem_col] = req_elem_value;
               end
               REQ_WRITE_B: begin
                  if (int'(req_elem_row) < MAX_DIM && int'(req_elem_col) < MAX_DIM)
                     store_b[req_elem_row][req_elem_col] = req_elem_value;
               end
               REQ_COMPUTE: predict_products();
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_products.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected product: row %0d col %0d value %0d last %0b",
                           rsp_prod_row, rsp_prod_col, rsp_prod_value, rsp_last_product);
            end else begin
               exp_p = expected_products.pop_front();
               if (rsp_prod_value !== exp_p.value || rsp_prod_row !== exp_p.row ||
                   rsp_prod_col !== exp_p.col || rsp_last_product !== exp_p.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("product mismatch: exp row %0d col %0d value %0d last %0b, %s",
                              exp_p.row, exp_p.col, $signed(exp_p.value), exp_p.last,
                              $sformatf("got row %0d col %0d value %0d last %0b",
                                        rsp_prod_row, rsp_prod_col, rsp_prod_value,
                                        rsp_last_product));
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_products.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the integer matrix multiplier: clock, reset, stimulus, receiver, verdict.
module tb_top;
   import imm_pkg::*;

   localparam logic [1:0]           REQ_UNUSED     = 2'd3;  // spare request code, dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE      = 2'd3;  // index past the register list
   localparam int                   LONG_HOLD      = 300;
   localparam int                   SETTLE_CYCLES  = 16;    // longer than a result takes through the pipeline
   localparam int                   WATCHDOG_LIMIT = 3000;

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DIM_W-1:0]         csr_data;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_type;
   logic [IDX_W-1:0]         req_elem_row;
   logic [IDX_W-1:0]         req_elem_col;
   logic signed [DATA_W-1:0] req_elem_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_prod_value;
   logic [IDX_W-1:0]         rsp_prod_row;
   logic [IDX_W-1:0]         rsp_prod_col;
   logic                     rsp_last_product;

   int mismatches;
   int pending;

   // idle rates in percent, changed per stimulus mode
   int req_idle_pct;
   int rsp_idle_pct;

   // long receiver hold: stimulus bumps the request count, receiver serves it
   int hold_requests;
   int hold_served;
   int hold_left;

   int quiet_cycles;

   // effective sizes of the current setting, and which elements hold data,
   // so a compute never reads an element that was never written
   int eff_rows;
   int eff_inner;
   int eff_cols;
   bit a_written [MAX_DIM][MAX_DIM];
   bit b_written [MAX_DIM][MAX_DIM];

   integer_matrix_multiply dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_elem_row     (req_elem_row),
      .req_elem_col     (req_elem_col),
      .req_elem_value   (req_elem_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prod_value   (rsp_prod_value),
      .rsp_prod_row     (rsp_prod_row),
      .rsp_prod_col     (rsp_prod_col),
      .rsp_last_product (rsp_last_product)
   );

   imm_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_elem_row     (req_elem_row),
      .req_elem_col     (req_elem_col),
      .req_elem_value   (req_elem_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prod_value   (rsp_prod_value),
      .rsp_prod_row     (rsp_prod_row),
      .rsp_prod_col     (rsp_prod_col),
      .rsp_last_product (rsp_last_product),
      .mismatch_count   (mismatches),
      .pending_count    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // same clamp as the block: 0 acts as 1, above MAX_DIM acts as MAX_DIM
   function automatic int dim_used(input logic [DIM_W-1:0] r);
      if (r == '0) return 1;
      if (int'(r) > MAX_DIM) return MAX_DIM;
      return int'(r);
   endfunction

   // element values lean toward the overflow corners
   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] v;
      case ($urandom_range(5))
         0:       v = 32'h8000_0000;
         1:       v = 32'h7fff_ffff;
         2:       v = 32'hffff_ffff;
         3:       v = DATA_W'($urandom_range(15));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // mostly small matrices, now and then any register value incl. 0 and > MAX_DIM
   function automatic logic [DIM_W-1:0] pick_dim();
      if ($urandom_range(3) == 0) return DIM_W'($urandom_range(15));
      return DIM_W'($urandom_range(3, 1));
   endfunction

   // One request transfer. Returns in the time step of the accepting edge,
   // with no assignment to req_valid made in that step yet.
   task automatic send_req(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_elem_row   <= row;
      req_elem_col   <= col;
      req_elem_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind == REQ_WRITE_A) a_written[row][col] = 1'b1;
      if (kind == REQ_WRITE_B) b_written[row][col] = 1'b1;
   endtask

   // spare code or a stray write anywhere in the stores
   task automatic send_noise();
      case ($urandom_range(2))
         0: send_req(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
         1: send_req(REQ_WRITE_A, IDX_W'($urandom), IDX_W'($urandom), pick_value());
         default: send_req(REQ_WRITE_B, IDX_W'($urandom), IDX_W'($urandom), pick_value());
      endcase
   endtask

   // Drop valid, let every expected product drain, then let the pipeline settle.
   // The first edge lets the checker account for a compute taken just now.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // new matrix sizes, written only with the block idle
   task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                           input logic [DIM_W-1:0] c);
      wait_idle();
      write_reg(CSR_SPARE, DIM_W'($urandom));   // must leave all three sizes alone
      write_reg(CSR_ROWS_A, r);
      write_reg(CSR_INNER_DIM, k);
      write_reg(CSR_COLS_B, c);
      csr_valid <= 1'b0;
      eff_rows  = dim_used(r);
      eff_inner = dim_used(k);
      eff_cols  = dim_used(c);
   endtask

   // Well-formed sequence: (re)load the elements the current sizes read, with
   // noise sprinkled in, then compute. Without refresh_all, elements that hold
   // data already are rewritten only some of the time.
   task automatic run_product(input bit refresh_all);
      for (int i = 0; i < eff_rows; i++) begin
         for (int k = 0; k < eff_inner; k++) begin
            if (refresh_all || !a_written[i][k] || $urandom_range(99) < 60) begin
               if ($urandom_range(99) < 12) send_noise();
               send_req(REQ_WRITE_A, IDX_W'(i), IDX_W'(k), pick_value());
            end
         end
      end
      for (int k = 0; k < eff_inner; k++) begin
         for (int j = 0; j < eff_cols; j++) begin
            if (refresh_all || !b_written[k][j] || $urandom_range(99) < 60) begin
               if ($urandom_range(99) < 12) send_noise();
               send_req(REQ_WRITE_B, IDX_W'(k), IDX_W'(j), pick_value());
            end
         end
      end
      // row, column and value are don't-care on a compute: random content
      send_req(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
   endtask

   // Receiver: random ready, or a long hold when the stimulus asks for one.
   initial begin
      hold_served = 0;
      hold_left   = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: too long without any transfer on any channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      hold_requests  = 0;
      req_idle_pct   = 34;
      rsp_idle_pct   = 62;
      reset          <= 1'b1;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      req_valid      <= 1'b0;
      req_type       <= REQ_WRITE_A;
      req_elem_row   <= '0;
      req_elem_col   <= '0;
      req_elem_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // 1x1x1: the overflow corners of a single product
      set_dims(4'd1, 4'd1, 4'd1);
      send_req(REQ_WRITE_A, 3'd0, 3'd0, 32'h8000_0000);
      send_req(REQ_WRITE_B, 3'd0, 3'd0, 32'hffff_ffff);
      send_req(REQ_COMPUTE, 3'd0, 3'd0, 32'h0);           // most negative times -1 wraps
      send_req(REQ_UNUSED, 3'd0, 3'd0, 32'h1234_5678);    // spare code, A must not change
      send_req(REQ_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
      send_req(REQ_WRITE_A, 3'd0, 3'd0, 32'h7fff_ffff);
      send_req(REQ_WRITE_B, 3'd0, 3'd0, 32'h7fff_ffff);
      send_req(REQ_COMPUTE, 3'd0, 3'd0, 32'h0);
      // highest index on both fields
      send_req(REQ_WRITE_A, 3'd7, 3'd7, 32'h8000_0000);
      send_req(REQ_WRITE_B, 3'd7, 3'd7, 32'h7fff_ffff);
      // all sizes zero behave as one
      set_dims(4'd0, 4'd0, 4'd0);
      send_req(REQ_COMPUTE, 3'd0, 3'd0, 32'h0);
      // non-square product, sums of corner values wrap
      set_dims(4'd2, 4'd3, 4'd2);
      for (int i = 0; i < 2; i++)
         for (int k = 0; k < 3; k++)
            send_req(REQ_WRITE_A, IDX_W'(i), IDX_W'(k),
                     ((i + k) % 2 == 0) ? 32'h8000_0000 : 32'h7fff_ffff);
      for (int k = 0; k < 3; k++)
         for (int j = 0; j < 2; j++)
            send_req(REQ_WRITE_B, IDX_W'(k), IDX_W'(j),
                     (j == 0) ? 32'hffff_ffff : 32'h7fff_ffff);
      send_req(REQ_COMPUTE, 3'd0, 3'd0, 32'h0);

      // ---- random part, three idle modes ----
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 34;
               rsp_idle_pct = 62;
            end
            1: begin
               req_idle_pct = 62;
               rsp_idle_pct = 34;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         if (mode == 0) begin
            // fill both stores completely, after which any size is safe
            set_dims(4'd8, 4'd8, 4'd8);
            run_product(1'b1);
            // sizes above MAX_DIM clamp
            set_dims(4'd15, 4'd9, 4'd12);
            send_req(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
         end
         if (mode == 2) begin
            // receiver holds off while computes keep coming: output fills up,
            // the sequencer stalls and req_ready stays low
            set_dims(4'd8, 4'd4, 4'd8);
            hold_requests++;
            repeat (3) begin
               send_req(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
               send_req(REQ_WRITE_A, IDX_W'($urandom), IDX_W'($urandom), pick_value());
            end
         end
         for (int phase = 0; phase < 2; phase++) begin
            set_dims(pick_dim(), pick_dim(), pick_dim());
            repeat (2) run_product($urandom_range(3) == 0);
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
